[hdl/atdp_pkg.sv]
// Shared constants, types and helper functions for the ASCII triple decimal parser.
package atdp_pkg;

  localparam int VAL_W           = 64;
  localparam int CHAR_W          = 8;
  localparam int FCNT_W          = 4;
  localparam int FCNT_DEPTH      = 1 << FCNT_W;
  localparam int DIGIT_W         = 4;
  localparam int FRAC_DIGITS_DEF = 9;
  localparam int FRAC_BITS_DEF   = 32;

  localparam logic [VAL_W-1:0] MAG_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_N     = 8'h4E;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;

  typedef struct packed {
    logic int_sat;
    logic frac_taken;
  } atdp_digit_status_t;

  // 10^(k+1): weight of the k-th fraction digit is 2^FRAC_BITS / 10^(k+1)
  function automatic logic [VAL_W-1:0] pow_ten(input int k);
    logic [VAL_W-1:0] p;
    p = VAL_W'(10);
    for (int i = 0; i < k; i++) begin
      p = p * VAL_W'(10);
    end
    return p;
  endfunction

endpackage

[hdl/atdp_digit_acc.sv]
// Digit accumulate step: integer part times ten plus the digit with saturation, fraction digit by weight.
module atdp_digit_acc import atdp_pkg::*; #(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic [VAL_W-1:0]   acc_i,
  input  logic               in_fraction_i,
  input  logic [FCNT_W-1:0]  frac_count_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output logic [VAL_W-1:0]   acc_o,
  output atdp_digit_status_t status_o
);

  localparam int INT_W  = VAL_W - 1 - FRAC_BITS;
  localparam int WIDE_W = INT_W + 4;
  localparam int PROD_W = FRAC_BITS + DIGIT_W;

  logic [FRAC_BITS-1:0] weight_tab [FCNT_DEPTH];

  // rounded weight of each fraction position, zero past the last used digit
  for (genvar k = 0; k < FCNT_DEPTH; k++) begin : g_weight
    localparam logic [VAL_W-1:0] P = pow_ten(k);
    localparam logic [VAL_W-1:0] W = (k < FRAC_DIGITS) ?
      (((VAL_W'(1) << FRAC_BITS) + P / 2) / P) : '0;
    assign weight_tab[k] = FRAC_BITS'(W);
  end

  logic [INT_W-1:0]  int_part;
  logic [WIDE_W-1:0] int_wide;
  logic              int_ovf;
  logic [INT_W-1:0]  int_new;
  logic              frac_ok;
  logic [PROD_W-1:0] frac_prod;
  logic [VAL_W:0]    frac_sum;
  logic              frac_ovf;

  always_comb begin
    int_part  = acc_i[VAL_W-2:FRAC_BITS];
    int_wide  = WIDE_W'({int_part, 3'b000}) + WIDE_W'({int_part, 1'b0}) + WIDE_W'(digit_i);
    int_ovf   = |int_wide[WIDE_W-1:INT_W];
    int_new   = int_ovf ? {INT_W{1'b1}} : int_wide[INT_W-1:0];
    frac_ok   = frac_count_i < FCNT_W'(FRAC_DIGITS);
    frac_prod = PROD_W'(digit_i) * PROD_W'(weight_tab[frac_count_i]);
    frac_sum  = {1'b0, acc_i} + (VAL_W+1)'(frac_prod);
    frac_ovf  = |frac_sum[VAL_W:VAL_W-1];

    if (!in_fraction_i) begin
      acc_o = {1'b0, int_new, {FRAC_BITS{1'b0}}};
    end else if (frac_ok) begin
      acc_o = frac_ovf ? MAG_MAX : frac_sum[VAL_W-1:0];
    end else begin
      acc_o = acc_i;
    end

    status_o.int_sat    = !in_fraction_i && int_ovf;
    status_o.frac_taken = in_fraction_i && frac_ok;
  end

endmodule

[hdl/ascii_triple_decimal_parser_top.sv]
// Top level of the ASCII triple decimal parser: byte intake, field state and result register.
//
// Usage:
//   The input channel (in_valid/in_ready/in_char_byte) takes one message byte per
//   item. A message holds latitude and longitude, each closed by 'N', then the
//   altitude, closed by the NUL byte. Each field is signed fixed point with
//   FRAC_BITS fraction bits (Q31.32 by default). A message starting with '*'
//   is skipped and reported with out_skipped set.
//   The result channel (out_valid/out_ready/out_*) gives one item per NUL byte.
//   Latency: the result is valid in the cycle after the NUL byte is accepted.
//   Throughput: one byte per cycle unless stalled as below; each byte is handled in a
//   single pass over the field state, digits through the digit multiply-accumulate.
//   Stall: while a result waits and out_ready is low, in_ready is low for every
//   byte, ordinary or NUL, so intake holds until the receiver takes the result;
//   a result taken in the same cycle frees the register for the next one.
//   Reset (rst_n low, synchronous) clears the message state and drops out_valid.
module ascii_triple_decimal_parser_top import atdp_pkg::*; #(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHAR_W-1:0]       in_char_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_latitude,
  output logic signed [VAL_W-1:0] out_longitude,
  output logic signed [VAL_W-1:0] out_altitude,
  output logic [1:0]              out_fields_done,
  output logic                    out_format_error,
  output logic                    out_skipped
);

  // field state
  logic [1:0]        field_index_r, field_index_nxt;
  logic              in_fraction_r, in_fraction_nxt;
  logic              is_negative_r, is_negative_nxt;
  logic              at_field_start_r, at_field_start_nxt;
  logic              at_msg_start_r, at_msg_start_nxt;
  logic              skip_msg_r, skip_msg_nxt;
  logic [FCNT_W-1:0] frac_count_r, frac_count_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [VAL_W-1:0]  done_val_r [2];
  logic [VAL_W-1:0]  done_val_nxt [2];
  logic              error_seen_r, error_seen_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  lat_r, lat_nxt;
  logic [VAL_W-1:0]  lon_r, lon_nxt;
  logic [VAL_W-1:0]  alt_r, alt_nxt;
  logic [1:0]        done_cnt_r, done_cnt_nxt;
  logic              fmt_err_r, fmt_err_nxt;
  logic              skipped_r, skipped_nxt;

  logic                 accept;
  logic                 is_nul;
  logic                 is_digit;
  logic [VAL_W-1:0]     signed_val;
  logic [VAL_W-1:0]     digit_acc;
  logic [DIGIT_W-1:0]   digit_val;
  atdp_digit_status_t   digit_status;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_nul     = in_char_byte == CHAR_NUL;
  assign is_digit   = (in_char_byte >= CHAR_ZERO) && (in_char_byte <= CHAR_NINE);
  assign digit_val  = DIGIT_W'(in_char_byte - CHAR_ZERO);
  assign signed_val = is_negative_r ? (VAL_W'(0) - acc_r) : acc_r;

  atdp_digit_acc #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_digit (
    .acc_i         (acc_r),
    .in_fraction_i (in_fraction_r),
    .frac_count_i  (frac_count_r),
    .digit_i       (digit_val),
    .acc_o         (digit_acc),
    .status_o      (digit_status)
  );

  always_comb begin
    field_index_nxt    = field_index_r;
    in_fraction_nxt    = in_fraction_r;
    is_negative_nxt    = is_negative_r;
    at_field_start_nxt = at_field_start_r;
    at_msg_start_nxt   = at_msg_start_r;
    skip_msg_nxt       = skip_msg_r;
    frac_count_nxt     = frac_count_r;
    acc_nxt            = acc_r;
    done_val_nxt       = done_val_r;
    error_seen_nxt     = error_seen_r;

    // drop the result once taken; load a new one on NUL
    out_valid_nxt = out_valid_r && !out_ready;
    lat_nxt       = lat_r;
    lon_nxt       = lon_r;
    alt_nxt       = alt_r;
    done_cnt_nxt  = done_cnt_r;
    fmt_err_nxt   = fmt_err_r;
    skipped_nxt   = skipped_r;

    if (accept) begin
      if (is_nul) begin
        out_valid_nxt = 1'b1;
        lat_nxt       = '0;
        lon_nxt       = '0;
        alt_nxt       = '0;
        done_cnt_nxt  = 2'd0;
        fmt_err_nxt   = error_seen_r;
        skipped_nxt   = 1'b0;
        if (skip_msg_r) begin
          skipped_nxt = 1'b1;
          fmt_err_nxt = 1'b0;
        end else if (field_index_r[1]) begin
          lat_nxt      = done_val_r[0];
          lon_nxt      = done_val_r[1];
          alt_nxt      = signed_val;
          done_cnt_nxt = 2'd3;
        end else if (field_index_r[0]) begin
          // early end inside longitude
          lat_nxt      = done_val_r[0];
          lon_nxt      = signed_val;
          done_cnt_nxt = 2'd1;
          fmt_err_nxt  = 1'b1;
        end else begin
          // early end inside latitude
          lat_nxt     = signed_val;
          fmt_err_nxt = 1'b1;
        end

        // return to the start-of-message state
        field_index_nxt    = 2'd0;
        in_fraction_nxt    = 1'b0;
        is_negative_nxt    = 1'b0;
        at_field_start_nxt = 1'b1;
        at_msg_start_nxt   = 1'b1;
        skip_msg_nxt       = 1'b0;
        frac_count_nxt     = '0;
        acc_nxt            = '0;
        done_val_nxt[0]    = '0;
        done_val_nxt[1]    = '0;
        error_seen_nxt     = 1'b0;
      end else begin
        at_msg_start_nxt = 1'b0;
        priority if (at_msg_start_r && in_char_byte == CHAR_STAR) begin
          skip_msg_nxt = 1'b1;
        end else if (skip_msg_r) begin
          // ignore the rest of a skipped message
        end else if (field_index_r == 2'd3) begin
          error_seen_nxt = 1'b1;
        end else if (is_digit) begin
          acc_nxt            = digit_acc;
          error_seen_nxt     = error_seen_r || digit_status.int_sat;
          frac_count_nxt     = frac_count_r + FCNT_W'(digit_status.frac_taken);
          at_field_start_nxt = 1'b0;
        end else if (in_char_byte == CHAR_MINUS && at_field_start_r) begin
          is_negative_nxt    = 1'b1;
          at_field_start_nxt = 1'b0;
        end else if (in_char_byte == CHAR_DOT && !in_fraction_r) begin
          in_fraction_nxt    = 1'b1;
          at_field_start_nxt = 1'b0;
        end else if (in_char_byte == CHAR_N) begin
          if (!field_index_r[1]) begin
            // close latitude or longitude and open the next field
            done_val_nxt[field_index_r[0]] = signed_val;
            field_index_nxt    = field_index_r + 2'd1;
            in_fraction_nxt    = 1'b0;
            is_negative_nxt    = 1'b0;
            at_field_start_nxt = 1'b1;
            frac_count_nxt     = '0;
            acc_nxt            = '0;
          end else begin
            // altitude closed; anything but NUL is an error from here
            field_index_nxt    = 2'd3;
            at_field_start_nxt = 1'b0;
          end
        end else begin
          error_seen_nxt     = 1'b1;
          at_field_start_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_index_r    <= 2'd0;
      in_fraction_r    <= 1'b0;
      is_negative_r    <= 1'b0;
      at_field_start_r <= 1'b1;
      at_msg_start_r   <= 1'b1;
      skip_msg_r       <= 1'b0;
      frac_count_r     <= '0;
      acc_r            <= '0;
      done_val_r[0]    <= '0;
      done_val_r[1]    <= '0;
      error_seen_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      field_index_r    <= field_index_nxt;
      in_fraction_r    <= in_fraction_nxt;
      is_negative_r    <= is_negative_nxt;
      at_field_start_r <= at_field_start_nxt;
      at_msg_start_r   <= at_msg_start_nxt;
      skip_msg_r       <= skip_msg_nxt;
      frac_count_r     <= frac_count_nxt;
      acc_r            <= acc_nxt;
      done_val_r       <= done_val_nxt;
      error_seen_r     <= error_seen_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    lat_r      <= lat_nxt;
    lon_r      <= lon_nxt;
    alt_r      <= alt_nxt;
    done_cnt_r <= done_cnt_nxt;
    fmt_err_r  <= fmt_err_nxt;
    skipped_r  <= skipped_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_latitude     = lat_r;
  assign out_longitude    = lon_r;
  assign out_altitude     = alt_r;
  assign out_fields_done  = done_cnt_r;
  assign out_format_error = fmt_err_r;
  assign out_skipped      = skipped_r;

endmodule

[bench/atdp_result_checker.sv]
// Result checker for the ASCII triple decimal parser: tracks bytes, predicts and compares results.
module atdp_result_checker import atdp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [CHAR_W-1:0]       in_char_byte,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [VAL_W-1:0] out_latitude,
  input  logic signed [VAL_W-1:0] out_longitude,
  input  logic signed [VAL_W-1:0] out_altitude,
  input  logic [1:0]              out_fields_done,
  input  logic                    out_format_error,
  input  logic                    out_skipped,
  output int                      mismatches,
  output int                      pending
);

  localparam int FRAC_DIGITS = FRAC_DIGITS_DEF;
  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam logic [VAL_W-1:0] INT_LIMIT = MAG_MAX >> FRAC_BITS;

  typedef struct {
    logic signed [VAL_W-1:0] lat;
    logic signed [VAL_W-1:0] lon;
    logic signed [VAL_W-1:0] alt;
    logic [1:0]              done;
    logic                    err;
    logic                    skip;
  } fix_t;

  fix_t fix_q[$];

  logic [1:0]        fld_idx;
  logic              in_frac;
  logic              neg;
  logic              fld_start;
  logic              msg_start;
  logic              skipping;
  logic [3:0]        frac_cnt;
  logic [VAL_W-1:0]  mag;
  logic [VAL_W-1:0]  done_val [2];
  logic              err;

  function automatic void clear_field();
    in_frac   = 1'b0;
    neg       = 1'b0;
    fld_start = 1'b1;
    frac_cnt  = '0;
    mag       = '0;
  endfunction

  function automatic void clear_message();
    fld_idx     = '0;
    clear_field();
    msg_start   = 1'b1;
    skipping    = 1'b0;
    done_val[0] = '0;
    done_val[1] = '0;
    err         = 1'b0;
  endfunction

  function automatic logic [VAL_W-1:0] field_value();
    return neg ? -mag : mag;
  endfunction

  // Integer digits shift the whole part by ten; fraction digits add a rounded 10^-k weight.
  function automatic void add_digit(input logic [VAL_W-1:0] d);
    logic [VAL_W-1:0] ip;
    logic [VAL_W-1:0] p;
    logic [VAL_W-1:0] w;
    if (!in_frac) begin
      ip = mag >> FRAC_BITS;
      if (ip > (INT_LIMIT - d) / 10) begin
        ip  = INT_LIMIT;
        err = 1'b1;
      end else begin
        ip = ip * 10 + d;
      end
      mag = ip << FRAC_BITS;
    end else if (frac_cnt < FRAC_DIGITS) begin
      p = 10;
      for (int i = 0; i < frac_cnt; i++) begin
        p = p * 10;
      end
      w   = ((VAL_W'(1) << FRAC_BITS) + p / 2) / p;
      mag = mag + d * w;
      if (mag > MAG_MAX) begin
        mag = MAG_MAX;
      end
      frac_cnt = frac_cnt + 1'b1;
    end
  endfunction

  function automatic void parse_byte(input logic [CHAR_W-1:0] c);
    fix_t r;
    if (c == CHAR_NUL) begin
      r.lat  = '0;
      r.lon  = '0;
      r.alt  = '0;
      r.done = '0;
      r.err  = err;
      r.skip = 1'b0;
      if (skipping) begin
        r.skip = 1'b1;
        r.err  = 1'b0;
      end else if (fld_idx >= 2) begin
        r.lat  = done_val[0];
        r.lon  = done_val[1];
        r.alt  = field_value();
        r.done = 2'd3;
      end else begin
        r.err  = 1'b1;
        r.done = fld_idx;
        if (fld_idx == 0) begin
          r.lat = field_value();
        end else begin
          r.lat = done_val[0];
          r.lon = field_value();
        end
      end
      fix_q.push_back(r);
      clear_message();
      return;
    end
    if (msg_start) begin
      msg_start = 1'b0;
      if (c == CHAR_STAR) begin
        skipping = 1'b1;
        return;
      end
    end
    if (skipping) return;
    if (fld_idx == 2'd3) begin
      err = 1'b1;
      return;
    end
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      add_digit(VAL_W'(c - CHAR_ZERO));
      fld_start = 1'b0;
    end else if (c == CHAR_MINUS && fld_start) begin
      neg       = 1'b1;
      fld_start = 1'b0;
    end else if (c == CHAR_DOT && !in_frac) begin
      in_frac   = 1'b1;
      fld_start = 1'b0;
    end else if (c == CHAR_N) begin
      if (fld_idx < 2) begin
        done_val[fld_idx] = field_value();
        fld_idx           = fld_idx + 1'b1;
        clear_field();
      end else begin
        fld_idx   = 2'd3;
        fld_start = 1'b0;
      end
    end else begin
      err       = 1'b1;
      fld_start = 1'b0;
    end
  endfunction

  function automatic void check_field(input string what, input logic [VAL_W-1:0] got,
                                      input logic [VAL_W-1:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
    end
  endfunction

  function automatic void compare_result();
    fix_t e;
    if (fix_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result with no message pending: lat %h lon %h alt %h",
                 out_latitude, out_longitude, out_altitude);
      end
      return;
    end
    e = fix_q.pop_front();
    check_field("latitude", out_latitude, e.lat);
    check_field("longitude", out_longitude, e.lon);
    check_field("altitude", out_altitude, e.alt);
    check_field("fields_done", VAL_W'(out_fields_done), VAL_W'(e.done));
    check_field("format_error", VAL_W'(out_format_error), VAL_W'(e.err));
    check_field("skipped", VAL_W'(out_skipped), VAL_W'(e.skip));
  endfunction

  // Retire results before taking bytes: a result never leaves in the cycle of its NUL.
  always @(posedge clk) begin
    if (!rst_n) begin
      fix_q.delete();
      clear_message();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) parse_byte(in_char_byte);
    end
    pending = fix_q.size();
  end

endmodule

[bench/testbench.sv]
// Testbench top for the ASCII triple decimal parser: stimulus, flow control and verdict.
module testbench import atdp_pkg::*;;

  localparam int HOLD_CYCLES = 300;     // long receiver hold-off to back up the input
  localparam int PHASE_BYTES = 400;     // random bytes per idling phase
  localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [CHAR_W-1:0]       in_char_byte = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic signed [VAL_W-1:0] out_latitude;
  logic signed [VAL_W-1:0] out_longitude;
  logic signed [VAL_W-1:0] out_altitude;
  logic [1:0]              out_fields_done;
  logic                    out_format_error;
  logic                    out_skipped;

  int mismatches;
  int pending;

  // Flow control knobs, percent of cycles spent idle or stalled.
  int   send_idle  = 0;
  int   recv_stall = 0;
  int   idle_tab [4] = '{0, 83, 0, 37};
  int   stall_tab[4] = '{0, 0, 83, 37};
  logic hold_req   = 1'b0;
  int   hold_left  = 0;
  int   cycle_cnt  = 0;
  int   bytes_sent = 0;

  // Bytes of the message being built, NUL included.
  logic [CHAR_W-1:0] frame[$];

  ascii_triple_decimal_parser_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_latitude     (out_latitude),
    .out_longitude    (out_longitude),
    .out_altitude     (out_altitude),
    .out_fields_done  (out_fields_done),
    .out_format_error (out_format_error),
    .out_skipped      (out_skipped)
  );

  atdp_result_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_latitude     (out_latitude),
    .out_longitude    (out_longitude),
    .out_altitude     (out_altitude),
    .out_fields_done  (out_fields_done),
    .out_format_error (out_format_error),
    .out_skipped      (out_skipped),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  always #5 clk = ~clk;

  // Abort a hung run: the block never drains or a handshake never completes.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Count down the long hold-off; a one-cycle hold_req pulse arms it.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: drop ready at random, and hold it low for the whole hold-off.
  always @(posedge clk) begin
    out_ready <= (hold_left == 0) && !hold_req && ($urandom_range(0, 99) >= recv_stall);
  end

  // Offer one byte; idle first at random, then hold valid and payload until taken.
  // Valid stays high on return so back-to-back bytes need no gap.
  task automatic send_byte(input logic [CHAR_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  // Send a literal message followed by its NUL.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(CHAR_W'(s[i]));
    send_byte(CHAR_NUL);
  endtask

  function automatic logic [CHAR_W-1:0] any_byte();
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [CHAR_W-1:0] any_digit();
    return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
  endfunction

  // Append one decimal: optional sign, mostly short digit runs, now and then long ones
  // to hit integer saturation and fraction digits past the table.
  function automatic void add_field();
    int n_int;
    int n_frac;
    if ($urandom_range(0, 3) == 0) frame.push_back(CHAR_MINUS);
    n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 4);
    repeat (n_int) frame.push_back(any_digit());
    if ($urandom_range(0, 2) != 0) begin
      frame.push_back(CHAR_DOT);
      n_frac = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 6);
      repeat (n_frac) frame.push_back(any_digit());
    end
  endfunction

  function automatic void add_triple();
    add_field();
    frame.push_back(CHAR_N);
    add_field();
    frame.push_back(CHAR_N);
    add_field();
    // Close the altitude with 'N' at times, maybe with a stray byte behind it.
    if ($urandom_range(0, 4) == 0) begin
      frame.push_back(CHAR_N);
      if ($urandom_range(0, 1) == 0) frame.push_back(any_byte());
    end
  endfunction

  // Build one random message: mostly well formed, the rest corrupted, cut short,
  // skipped or plain noise.
  function automatic void build_frame();
    int kind;
    int cut;
    frame.delete();
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      add_triple();
    end else if (kind < 80) begin
      add_triple();
      frame.insert($urandom_range(0, frame.size()), any_byte());
    end else if (kind < 88) begin
      add_triple();
      cut = $urandom_range(0, frame.size());
      while (frame.size() > cut) void'(frame.pop_back());
    end else if (kind < 94) begin
      frame.push_back(CHAR_STAR);
      repeat ($urandom_range(0, 8)) frame.push_back(any_byte());
    end else begin
      repeat ($urandom_range(0, 8)) frame.push_back(any_byte());
    end
    frame.push_back(CHAR_NUL);
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed messages: plain values, empty and skipped messages, field extremes,
    // saturation, excess fraction digits, unexpected bytes, early ends.
    send_text("12.5N-7.25N100");
    send_text("");
    send_text("*junk-.N");
    send_text("*");
    send_text("2147483647.999999999N-2147483647.9999999999999N0.000000001");
    send_text("99999999999N-4294967296N0");
    send_text("1-2N3..4N5x");
    send_text("1N2N3N45");
    send_text("-3.5");
    send_text("1N-2.7");
    send_text("-N-N-");
    send_text(".N.N.");
    send_text("7\377\001N*N9");
    send_text("N5");

    // Random messages through the idling phases. Arm the long hold-off at the
    // start of the first phase so the input backs up behind a waiting result.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  <= idle_tab[ph];
      recv_stall <= stall_tab[ph];
      if (ph == 0) begin
        in_valid <= 1'b0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      while (bytes_sent < (ph + 1) * PHASE_BYTES + 200) begin
        build_frame();
        send_frame();
      end
    end

    // Drain: wait for every expected result, sampling away from the clock edge.
    in_valid   <= 1'b0;
    recv_stall <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/atdp_pkg.sv
hdl/atdp_digit_acc.sv
hdl/ascii_triple_decimal_parser_top.sv
bench/atdp_result_checker.sv
bench/testbench.sv
